// ----- rtl/core/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the takeoff sequencer with PID throttle.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_ABORT  = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ARMCHECK = 3'd1;
    localparam logic [2:0] PH_CLIMB    = 3'd2;
    localparam logic [2:0] PH_STAB     = 3'd3;
    localparam logic [2:0] PH_COMPLETE = 3'd4;
    localparam logic [2:0] PH_ABORTED  = 3'd5;

    localparam logic [10:0] NEUTRAL_PWM  = 11'd1500;
    localparam int          ADJ_LIMIT    = 300;
    localparam logic [4:0]  NUM_CHANNELS = 5'd18;

    localparam logic [2:0] REG_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_STAB     = 3'd1;
    localparam logic [2:0] REG_GAIN_P   = 3'd2;
    localparam logic [2:0] REG_GAIN_I   = 3'd3;
    localparam logic [2:0] REG_GAIN_D   = 3'd4;
    localparam logic [2:0] REG_DEADBAND = 3'd5;
    localparam logic [2:0] REG_CHANNEL  = 3'd6;

    // reciprocals ceil(2^k/d); exact quotients for |x| < 2^48 (d = 10)
    // and |x| < 2^61 (d = 10^7)
    localparam logic signed [63:0] RCP10_M   = 64'sd450359962737050;
    localparam int                 RCP10_SH  = 52;
    localparam logic signed [63:0] RCP1E7_M  = 64'sd3868562622766813360;
    localparam int                 RCP1E7_SH = 85;

    // PID micro-steps, one pass of the shared mul/div unit each
    localparam logic [3:0] ST_EDT   = 4'd0;
    localparam logic [3:0] ST_PMUL  = 4'd1;
    localparam logic [3:0] ST_PDIV  = 4'd2;
    localparam logic [3:0] ST_IDIV  = 4'd3;
    localparam logic [3:0] ST_IREM  = 4'd4;
    localparam logic [3:0] ST_IMUL1 = 4'd5;
    localparam logic [3:0] ST_IMUL2 = 4'd6;
    localparam logic [3:0] ST_IDIV2 = 4'd7;
    localparam logic [3:0] ST_DMUL1 = 4'd8;
    localparam logic [3:0] ST_DMUL2 = 4'd9;
    localparam logic [3:0] ST_DDIV  = 4'd10;
    localparam logic [3:0] ST_LAST  = ST_DDIV;

    localparam logic MD_MUL = 1'b0;
    localparam logic MD_DIV = 1'b1;

    typedef struct packed {
        logic [31:0]        phase_limit_ms;
        logic [31:0]        stabilize_ms;
        logic signed [23:0] gain_p;
        logic signed [23:0] gain_i;
        logic signed [23:0] gain_d;
        logic [15:0]        deadband_mm;
        logic [4:0]         throttle_channel;
    } tsp_cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       decide;
        logic       start;
        logic       store;
        logic       finish;
        logic       out_load;
        logic [3:0] step;
    } tsp_cmd_t;

    typedef struct packed {
        logic pid_go;
        logic unit_done;
    } tsp_stat_t;

endpackage

// ----- rtl/core/tsp_regs.sv -----
// ----------------------------------------------------------------------------
// tsp_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module tsp_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tsp_pkg::tsp_cfg_t cfg
);

    tsp_pkg::tsp_cfg_t cfg_reg;
    logic              wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_limit_ms   <= 32'd30000;
            cfg_reg.stabilize_ms     <= 32'd2000;
            cfg_reg.gain_p           <= 24'sd32768;
            cfg_reg.gain_i           <= 24'sd0;
            cfg_reg.gain_d           <= 24'sd0;
            cfg_reg.deadband_mm      <= 16'd500;
            cfg_reg.throttle_channel <= 5'd2;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                tsp_pkg::REG_TIMEOUT:  cfg_reg.phase_limit_ms   <= pwdata;
                tsp_pkg::REG_STAB:     cfg_reg.stabilize_ms     <= pwdata;
                tsp_pkg::REG_GAIN_P:   cfg_reg.gain_p           <= pwdata[23:0];
                tsp_pkg::REG_GAIN_I:   cfg_reg.gain_i           <= pwdata[23:0];
                tsp_pkg::REG_GAIN_D:   cfg_reg.gain_d           <= pwdata[23:0];
                tsp_pkg::REG_DEADBAND: cfg_reg.deadband_mm      <= pwdata[15:0];
                tsp_pkg::REG_CHANNEL:  cfg_reg.throttle_channel <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            tsp_pkg::REG_TIMEOUT:  prdata = cfg_reg.phase_limit_ms;
            tsp_pkg::REG_STAB:     prdata = cfg_reg.stabilize_ms;
            tsp_pkg::REG_GAIN_P:   prdata = {{8{cfg_reg.gain_p[23]}}, cfg_reg.gain_p};
            tsp_pkg::REG_GAIN_I:   prdata = {{8{cfg_reg.gain_i[23]}}, cfg_reg.gain_i};
            tsp_pkg::REG_GAIN_D:   prdata = {{8{cfg_reg.gain_d[23]}}, cfg_reg.gain_d};
            tsp_pkg::REG_DEADBAND: prdata = {16'd0, cfg_reg.deadband_mm};
            tsp_pkg::REG_CHANNEL:  prdata = {27'd0, cfg_reg.throttle_channel};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/tsp_muldiv.sv -----
// ----------------------------------------------------------------------------
// tsp_muldiv
// Shared signed shift-add multiplier and restoring divider, one bit per
// cycle. The multiplier keeps the full 128-bit product magnitude, used for
// reciprocal division by constants. Division truncates toward zero.
// ----------------------------------------------------------------------------
module tsp_muldiv
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               op,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] prod,
    output logic signed [63:0] quo,
    output logic [127:0]       mag
);

    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic         op_reg;
    logic         neg_q_reg;
    logic [63:0]  x_reg;
    logic [127:0] y_reg;
    logic [127:0] acc_reg;
    logic [63:0]  a_mag;
    logic [63:0]  b_mag;
    logic [64:0]  trial;

    assign a_mag = a[63] ? 64'(-a) : 64'(a);
    assign b_mag = b[63] ? 64'(-b) : 64'(b);
    assign trial = {1'b0, acc_reg[62:0], x_reg[63]} - {1'b0, y_reg[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= op;
            neg_q_reg <= a[63] ^ b[63];
            x_reg     <= a_mag;
            y_reg     <= {64'd0, b_mag};
            acc_reg   <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (op_reg == tsp_pkg::MD_MUL)
            begin
                if (x_reg[0])
                begin
                    acc_reg <= acc_reg + y_reg;
                end
                y_reg <= {y_reg[126:0], 1'b0};
                x_reg <= {1'b0, x_reg[63:1]};
            end
            else
            begin
                if (!trial[64])
                begin
                    acc_reg <= {64'd0, trial[63:0]};
                    x_reg   <= {x_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_reg <= {64'd0, acc_reg[62:0], x_reg[63]};
                    x_reg   <= {x_reg[62:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = neg_q_reg ? -signed'(acc_reg[63:0]) : signed'(acc_reg[63:0]);
    assign quo  = neg_q_reg ? -signed'(x_reg) : signed'(x_reg);
    assign mag  = acc_reg;

endmodule

// ----- rtl/core/tsp_dp.sv -----
// ----------------------------------------------------------------------------
// tsp_dp
// Datapath: input latch, phase and PID state, operand steering for the
// shared mul/div unit, result and output registers.
// ----------------------------------------------------------------------------
module tsp_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsp_pkg::tsp_cfg_t  cfg,
    input  tsp_pkg::tsp_cmd_t  cmd,
    output tsp_pkg::tsp_stat_t stat,
    input  logic [1:0]         in_operation,
    input  logic [39:0]        in_now_us,
    input  logic [19:0]        in_target_altitude_mm,
    input  logic signed [20:0] in_current_altitude_mm,
    input  logic               in_armed,
    input  logic               in_guided_mode,
    output logic [2:0]         phase,
    output logic               send_throttle,
    output logic [10:0]        throttle_pwm,
    output logic [4:0]         out_channel,
    output logic               send_takeoff_cmd,
    output logic [19:0]        takeoff_altitude_mm,
    output logic               operation_active,
    output logic               start_rejected
);

    // latched item
    logic [1:0]         op_reg;
    logic [39:0]        now_reg;
    logic [19:0]        tgt_in_reg;
    logic signed [20:0] cur_reg;
    logic               armed_reg;
    logic               guided_reg;

    // sequencer state
    logic [2:0]         phase_reg;
    logic               active_reg;
    logic [19:0]        target_reg;
    logic [39:0]        ps_reg;
    logic [39:0]        lu_reg;
    logic signed [21:0] prev_reg;
    logic signed [63:0] integ_reg;

    // PID work registers
    logic signed [63:0] tmp_reg;
    logic signed [63:0] tmp2_reg;
    logic signed [63:0] p_reg;
    logic signed [63:0] i_reg;
    logic signed [63:0] d_reg;

    // result of the step
    logic [2:0]         res_phase_reg;
    logic               res_thr_reg;
    logic [10:0]        res_pwm_reg;
    logic               res_cmd_reg;
    logic               res_active_reg;
    logic               res_rej_reg;

    // output beat
    logic [2:0]         out_phase_reg;
    logic               out_thr_reg;
    logic [10:0]        out_pwm_reg;
    logic [4:0]         out_ch_reg;
    logic               out_cmd_reg;
    logic [19:0]        out_alt_reg;
    logic               out_active_reg;
    logic               out_rej_reg;

    logic [39:0]        el;
    logic [39:0]        dt;
    logic [41:0]        tmo_lim;
    logic [41:0]        stab_lim;
    logic               tmo_hit;
    logic               stab_hit;
    logic signed [22:0] e_wide;
    logic signed [21:0] e;
    logic [21:0]        ae;
    logic               inband;
    logic signed [22:0] de;
    logic               in_flight;

    logic [2:0]         n_phase;
    logic               n_active;
    logic [19:0]        n_target;
    logic [39:0]        n_ps;
    logic [39:0]        n_lu;
    logic               n_clear_pid;
    logic               n_thr;
    logic [10:0]        n_pwm;
    logic               n_cmd;
    logic               n_rej;
    logic               pid_go;

    logic               md_op;
    logic signed [63:0] md_a;
    logic signed [63:0] md_b;
    logic               md_done;
    logic signed [63:0] md_prod;
    logic signed [63:0] md_quo;
    logic [127:0]       md_mag;
    logic [63:0]        q10_mag;
    logic [63:0]        q1e7_mag;
    logic signed [63:0] q10;
    logic signed [63:0] q1e7;
    logic signed [63:0] integ_sum;
    logic signed [63:0] integ_sat;

    logic signed [65:0] pid_sum;
    logic signed [65:0] pid_rnd;
    logic signed [49:0] pid_s;
    logic signed [10:0] adj;
    logic               ch_ok;

    assign el       = now_reg - ps_reg;
    assign dt       = now_reg - lu_reg;
    assign tmo_lim  = {10'd0, cfg.phase_limit_ms} * 42'd1000;
    assign stab_lim = {10'd0, cfg.stabilize_ms} * 42'd1000;
    assign tmo_hit  = {2'b00, el} > tmo_lim;
    assign stab_hit = {2'b00, el} > stab_lim;
    assign e_wide   = signed'({3'b000, target_reg}) - {{2{cur_reg[20]}}, cur_reg};
    assign de       = {e[21], e} - {prev_reg[21], prev_reg};
    assign ae       = e[21] ? 22'(-e) : 22'(e);
    assign inband   = ae < {6'd0, cfg.deadband_mm};
    assign in_flight = (phase_reg == tsp_pkg::PH_ARMCHECK) ||
                       (phase_reg == tsp_pkg::PH_CLIMB) ||
                       (phase_reg == tsp_pkg::PH_STAB);

    always_comb
    begin
        if (e_wide > 23'sd2097151)
        begin
            e = 22'sh1FFFFF;
        end
        else if (e_wide < -23'sd2097152)
        begin
            e = 22'sh200000;
        end
        else
        begin
            e = e_wide[21:0];
        end
    end

    always_comb
    begin
        n_phase     = phase_reg;
        n_active    = active_reg;
        n_target    = target_reg;
        n_ps        = ps_reg;
        n_lu        = lu_reg;
        n_clear_pid = 1'b0;
        n_thr       = 1'b0;
        n_pwm       = 11'd0;
        n_cmd       = 1'b0;
        n_rej       = 1'b0;
        pid_go      = 1'b0;
        if (op_reg == tsp_pkg::OP_START)
        begin
            if (active_reg)
            begin
                n_rej = 1'b1;
            end
            else
            begin
                n_target    = tgt_in_reg;
                n_active    = 1'b1;
                n_phase     = tsp_pkg::PH_ARMCHECK;
                n_ps        = now_reg;
                n_lu        = now_reg;
                n_clear_pid = 1'b1;
            end
        end
        else if (op_reg == tsp_pkg::OP_ABORT)
        begin
            n_active = 1'b0;
            n_phase  = tsp_pkg::PH_ABORTED;
            n_thr    = !guided_reg;
            n_pwm    = tsp_pkg::NEUTRAL_PWM;
        end
        else if (op_reg == tsp_pkg::OP_UPDATE && in_flight)
        begin
            if (tmo_hit)
            begin
                n_active = 1'b0;
                n_phase  = tsp_pkg::PH_ABORTED;
                n_thr    = !guided_reg;
                n_pwm    = tsp_pkg::NEUTRAL_PWM;
            end
            else if (phase_reg == tsp_pkg::PH_ARMCHECK)
            begin
                if (armed_reg)
                begin
                    n_phase = tsp_pkg::PH_CLIMB;
                    n_ps    = now_reg;
                end
            end
            else if (phase_reg == tsp_pkg::PH_CLIMB)
            begin
                if (inband)
                begin
                    n_phase = tsp_pkg::PH_STAB;
                    n_ps    = now_reg;
                    n_thr   = !guided_reg;
                    n_pwm   = tsp_pkg::NEUTRAL_PWM;
                end
                else
                begin
                    n_lu = now_reg;
                    if (guided_reg)
                    begin
                        n_cmd = 1'b1;
                    end
                    else
                    begin
                        n_thr  = 1'b1;
                        n_pwm  = tsp_pkg::NEUTRAL_PWM;
                        pid_go = dt != 40'd0;
                    end
                end
            end
            else if (stab_hit)
            begin
                n_phase  = tsp_pkg::PH_COMPLETE;
                n_active = 1'b0;
            end
        end
    end

    assign stat.pid_go    = pid_go;
    assign stat.unit_done = md_done;

    always_comb
    begin
        md_op = tsp_pkg::MD_MUL;
        md_a  = tmp_reg;
        md_b  = 64'sd0;
        case (cmd.step)
            tsp_pkg::ST_EDT:
            begin
                md_a = 64'(e);
                md_b = signed'({24'd0, dt});
            end
            tsp_pkg::ST_PMUL:
            begin
                md_a = 64'(cfg.gain_p);
                md_b = 64'(e);
            end
            tsp_pkg::ST_PDIV:
            begin
                md_b = tsp_pkg::RCP10_M;
            end
            tsp_pkg::ST_IDIV:
            begin
                md_a = integ_reg;
                md_b = tsp_pkg::RCP1E7_M;
            end
            tsp_pkg::ST_IREM:
            begin
                md_b = 64'sd10000000;
            end
            tsp_pkg::ST_IMUL1:
            begin
                md_a = 64'(cfg.gain_i);
                md_b = tmp_reg;
            end
            tsp_pkg::ST_IMUL2:
            begin
                md_a = 64'(cfg.gain_i);
                md_b = tmp2_reg;
            end
            tsp_pkg::ST_IDIV2:
            begin
                md_b = tsp_pkg::RCP1E7_M;
            end
            tsp_pkg::ST_DMUL1:
            begin
                md_a = 64'(cfg.gain_d);
                md_b = 64'(de);
            end
            tsp_pkg::ST_DMUL2:
            begin
                md_b = 64'sd100000;
            end
            tsp_pkg::ST_DDIV:
            begin
                md_op = tsp_pkg::MD_DIV;
                md_b  = signed'({24'd0, dt});
            end
            default: ;
        endcase
    end

    tsp_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .op    (md_op),
        .a     (md_a),
        .b     (md_b),
        .done  (md_done),
        .prod  (md_prod),
        .quo   (md_quo),
        .mag   (md_mag)
    );

    // reciprocal quotients, truncated toward zero with the dividend sign
    assign q10_mag  = 64'(md_mag >> tsp_pkg::RCP10_SH);
    assign q1e7_mag = 64'(md_mag >> tsp_pkg::RCP1E7_SH);
    assign q10      = md_a[63] ? -signed'(q10_mag) : signed'(q10_mag);
    assign q1e7     = md_a[63] ? -signed'(q1e7_mag) : signed'(q1e7_mag);

    assign integ_sum = integ_reg + md_prod;

    always_comb
    begin
        if (integ_sum > 64'sh1000_0000_0000_0000)
        begin
            integ_sat = 64'sh1000_0000_0000_0000;
        end
        else if (integ_sum < -64'sh1000_0000_0000_0000)
        begin
            integ_sat = -64'sh1000_0000_0000_0000;
        end
        else
        begin
            integ_sat = integ_sum;
        end
    end

    assign pid_sum = 66'(p_reg) + 66'(i_reg) + 66'(d_reg);
    assign pid_rnd = pid_sum[65] ? pid_sum + 66'sd65535 : pid_sum;
    assign pid_s   = pid_rnd[65:16];

    always_comb
    begin
        if (pid_s > 50'sd300)
        begin
            adj = 11'sd300;
        end
        else if (pid_s < -50'sd300)
        begin
            adj = -11'sd300;
        end
        else
        begin
            adj = pid_s[10:0];
        end
    end

    assign ch_ok = cfg.throttle_channel < tsp_pkg::NUM_CHANNELS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tsp_pkg::PH_IDLE;
            active_reg <= 1'b0;
            target_reg <= 20'd0;
            ps_reg     <= 40'd0;
            lu_reg     <= 40'd0;
            prev_reg   <= 22'sd0;
            integ_reg  <= 64'sd0;
        end
        else
        begin
            if (cmd.decide && !pid_go)
            begin
                phase_reg  <= n_phase;
                active_reg <= n_active;
                target_reg <= n_target;
                ps_reg     <= n_ps;
                lu_reg     <= n_lu;
                if (n_clear_pid)
                begin
                    prev_reg  <= 22'sd0;
                    integ_reg <= 64'sd0;
                end
            end
            if (cmd.store && cmd.step == tsp_pkg::ST_EDT)
            begin
                integ_reg <= integ_sat;
            end
            if (cmd.finish)
            begin
                lu_reg   <= now_reg;
                prev_reg <= e;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_operation;
            now_reg    <= in_now_us;
            tgt_in_reg <= in_target_altitude_mm;
            cur_reg    <= in_current_altitude_mm;
            armed_reg  <= in_armed;
            guided_reg <= in_guided_mode;
        end
        if (cmd.store)
        begin
            case (cmd.step)
                tsp_pkg::ST_PMUL:  tmp_reg  <= md_prod;
                tsp_pkg::ST_PDIV:  p_reg    <= q10;
                tsp_pkg::ST_IDIV:  tmp_reg  <= q1e7;
                tsp_pkg::ST_IREM:  tmp2_reg <= integ_reg - md_prod;
                tsp_pkg::ST_IMUL1: i_reg    <= md_prod;
                tsp_pkg::ST_IMUL2: tmp_reg  <= md_prod;
                tsp_pkg::ST_IDIV2: i_reg    <= i_reg + q1e7;
                tsp_pkg::ST_DMUL1: tmp_reg  <= md_prod;
                tsp_pkg::ST_DMUL2: tmp_reg  <= md_prod;
                tsp_pkg::ST_DDIV:  d_reg    <= md_quo;
                default: ;
            endcase
        end
        if (cmd.decide && !pid_go)
        begin
            res_phase_reg  <= n_phase;
            res_thr_reg    <= n_thr;
            res_pwm_reg    <= n_pwm;
            res_cmd_reg    <= n_cmd;
            res_active_reg <= n_active;
            res_rej_reg    <= n_rej;
        end
        if (cmd.finish)
        begin
            res_phase_reg  <= phase_reg;
            res_thr_reg    <= 1'b1;
            res_pwm_reg    <= tsp_pkg::NEUTRAL_PWM + adj;
            res_cmd_reg    <= 1'b0;
            res_active_reg <= active_reg;
            res_rej_reg    <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_phase_reg  <= res_phase_reg;
            out_thr_reg    <= res_thr_reg && ch_ok;
            out_pwm_reg    <= (res_thr_reg && ch_ok) ? res_pwm_reg : 11'd0;
            out_ch_reg     <= (res_thr_reg && ch_ok) ? cfg.throttle_channel : 5'd0;
            out_cmd_reg    <= res_cmd_reg;
            out_alt_reg    <= res_cmd_reg ? target_reg : 20'd0;
            out_active_reg <= res_active_reg;
            out_rej_reg    <= res_rej_reg;
        end
    end

    assign phase               = out_phase_reg;
    assign send_throttle       = out_thr_reg;
    assign throttle_pwm        = out_pwm_reg;
    assign out_channel         = out_ch_reg;
    assign send_takeoff_cmd    = out_cmd_reg;
    assign takeoff_altitude_mm = out_alt_reg;
    assign operation_active    = out_active_reg;
    assign start_rejected      = out_rej_reg;

endmodule

// ----- rtl/core/tsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsp_ctrl
// Controller: input/output handshakes and the PID step sequence.
// ----------------------------------------------------------------------------
module tsp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  tsp_pkg::tsp_stat_t stat,
    output tsp_pkg::tsp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       mvalid_reg;
    logic       mvalid_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.load_in  = 1'b0;
        cmd.decide   = 1'b0;
        cmd.start    = 1'b0;
        cmd.store    = 1'b0;
        cmd.finish   = 1'b0;
        cmd.out_load = 1'b0;
        cmd.step     = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                step_next  = tsp_pkg::ST_EDT;
                state_next = stat.pid_go ? S_ISSUE : S_DONE;
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (stat.unit_done)
                begin
                    cmd.store = 1'b1;
                    if (step_reg == tsp_pkg::ST_LAST)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= tsp_pkg::ST_EDT;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;

endmodule

// ----- rtl/core/takeoff_sequencer_pid_throttle.sv -----
// ----------------------------------------------------------------------------
// takeoff_sequencer_pid_throttle
// Takeoff phase sequencer with a PID throttle law.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry an operation in tuser and timestamp, altitudes and
// flags in tdata. Each beat yields exactly one output beat (m_*) with the
// new phase, throttle override, takeoff command and status flags.
// One item at a time: s_tready is high only while no item is in work.
// A manual-mode climbing update with nonzero dt runs eleven passes of the
// shared shift-add multiplier / restoring divider; other items skip them.
// The next item can be taken in the cycle after the result is handed to
// the output register, so a waiting output beat does not block the next
// input beat. If m_tready is low the finished item holds in the sequencer
// until the output register frees.
// Reset clears phase to idle, the PID integrator and previous error to zero
// and the configuration registers to their defaults. Configuration is over APB at 4*index.
// ----------------------------------------------------------------------------
module takeoff_sequencer_pid_throttle
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_us[39:0], target_altitude_mm[59:40], current_altitude_mm[80:60],
    // armed[81], guided_mode[82]
    input  logic [87:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase[2:0], send_throttle[3], throttle_pwm[14:4], out_channel[19:15],
    // send_takeoff_cmd[20], takeoff_altitude_mm[40:21], operation_active[41],
    // start_rejected[42]
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tsp_pkg::tsp_cfg_t  cfg;
    tsp_pkg::tsp_cmd_t  cmd;
    tsp_pkg::tsp_stat_t stat;

    logic [2:0]  phase;
    logic        send_throttle;
    logic [10:0] throttle_pwm;
    logic [4:0]  out_channel;
    logic        send_takeoff_cmd;
    logic [19:0] takeoff_altitude_mm;
    logic        operation_active;
    logic        start_rejected;

    tsp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsp_dp u_dp
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg                    (cfg),
        .cmd                    (cmd),
        .stat                   (stat),
        .in_operation           (s_tuser),
        .in_now_us              (s_tdata[39:0]),
        .in_target_altitude_mm  (s_tdata[59:40]),
        .in_current_altitude_mm (s_tdata[80:60]),
        .in_armed               (s_tdata[81]),
        .in_guided_mode         (s_tdata[82]),
        .phase                  (phase),
        .send_throttle          (send_throttle),
        .throttle_pwm           (throttle_pwm),
        .out_channel            (out_channel),
        .send_takeoff_cmd       (send_takeoff_cmd),
        .takeoff_altitude_mm    (takeoff_altitude_mm),
        .operation_active       (operation_active),
        .start_rejected         (start_rejected)
    );

    assign m_tdata = {5'd0, start_rejected, operation_active, takeoff_altitude_mm,
                      send_takeoff_cmd, out_channel, throttle_pwm, send_throttle, phase};

endmodule

// ----- rtl/core/tsp_checker.sv -----
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the takeoff sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped or changed while stalled");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= tsp_pkg::PH_ABORTED)
        else $error("phase code out of range");

    a_nothr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[19:4] == 16'd0)
        else $error("throttle fields set without override");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == tsp_pkg::PH_COMPLETE ||
                     m_tdata[2:0] == tsp_pkg::PH_ABORTED ||
                     m_tdata[2:0] == tsp_pkg::PH_IDLE)
        |-> !m_tdata[41])
        else $error("active flag set in a terminal phase");

    a_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[14:4] >= 11'd1200 && m_tdata[14:4] <= 11'd1800)
        else $error("throttle out of range");

endmodule

bind takeoff_sequencer_pid_throttle tsp_checker u_tsp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb_takeoff_sequencer_pid_throttle.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_takeoff_sequencer_pid_throttle
// Self-checking bench for the takeoff sequencer with PID throttle.
// ----------------------------------------------------------------------------
// Beats are predicted by an in-bench phase machine and PID model and checked
// field by field in order. Directed flights cover every operation and corner,
// then random flights run under several register settings with random
// stalls on both streams in all but one run.
// ----------------------------------------------------------------------------
module tb_takeoff_sequencer_pid_throttle;
    import tsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [2:0]  phase;
        logic        thr;
        logic [10:0] pwm;
        logic [4:0]  chan;
        logic        cmd;
        logic [19:0] alt;
        logic        act;
        logic        rej;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // controller copy
    logic [31:0] c_timeout, c_stab;
    longint      c_gp, c_gi, c_gd;
    logic [15:0] c_db;
    logic [4:0]  c_ch;
    logic [2:0]  fl_phase;
    logic        fl_active;
    longint      fl_target;
    logic [39:0] fl_phase_t0, fl_last_upd;
    longint      fl_prev_err, fl_integ;

    beat_t       pending_beats[$];
    int          errors, n_items, n_thr, n_cmd, n_abort, n_pid;
    int          stall_pct;
    int          idle_cycles;
    logic [39:0] clock_us;

    takeoff_sequencer_pid_throttle dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** takeoff_sequencer_pid_throttle: FAILED **");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, n_items);
        errors++;
    endtask

    always @(posedge clk)
    begin
        beat_t w;
        if (m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
                report("unexpected beat", 1, 0);
            else
            begin
                w = pending_beats.pop_front();
                if (m_tdata[2:0] !== w.phase) report("phase", m_tdata[2:0], w.phase);
                if (m_tdata[3] !== w.thr) report("send_throttle", m_tdata[3], w.thr);
                if (m_tdata[14:4] !== w.pwm) report("throttle_pwm", m_tdata[14:4], w.pwm);
                if (m_tdata[19:15] !== w.chan) report("out_channel", m_tdata[19:15], w.chan);
                if (m_tdata[20] !== w.cmd) report("send_takeoff_cmd", m_tdata[20], w.cmd);
                if (m_tdata[40:21] !== w.alt) report("takeoff_alt", m_tdata[40:21], w.alt);
                if (m_tdata[41] !== w.act) report("operation_active", m_tdata[41], w.act);
                if (m_tdata[42] !== w.rej) report("start_rejected", m_tdata[42], w.rej);
            end
        end
    end

    function automatic longint throttle_adjust(longint err, logic [39:0] now);
        logic [39:0] dt;
        longint acc, de, p, i, d, s;
        dt = now - fl_last_upd;
        if (dt == 0)
            return 0;
        acc = fl_integ + err * longint'(dt);
        if (acc > (longint'(1) << 60)) acc = longint'(1) << 60;
        if (acc < -(longint'(1) << 60)) acc = -(longint'(1) << 60);
        fl_integ = acc;
        de = err - fl_prev_err;
        p = c_gp * err / 10;
        i = c_gi * (acc / 10000000) + (c_gi * (acc % 10000000)) / 10000000;
        d = (c_gd * de * 100000) / longint'(dt);
        fl_prev_err = err;
        s = (p + i + d) / 65536;
        if (s > ADJ_LIMIT) s = ADJ_LIMIT;
        if (s < -ADJ_LIMIT) s = -ADJ_LIMIT;
        return s;
    endfunction

    function automatic beat_t fly_step(logic [1:0] op, logic [39:0] now, logic [19:0] tgt,
                                       logic signed [20:0] cur, logic armed, logic guided);
        beat_t b;
        logic [39:0] el;
        longint e, ae;
        logic thr, cmd, rej;
        logic [10:0] pwm;
        thr = 0; cmd = 0; rej = 0; pwm = 0;
        if (op == OP_START)
        begin
            if (fl_active)
                rej = 1;
            else
            begin
                fl_target = tgt;
                fl_active = 1;
                fl_phase = PH_ARMCHECK;
                fl_phase_t0 = now;
                fl_last_upd = now;
                fl_prev_err = 0;
                fl_integ = 0;
            end
        end
        else if (op == OP_ABORT)
        begin
            fl_active = 0;
            fl_phase = PH_ABORTED;
            if (!guided) begin thr = 1; pwm = NEUTRAL_PWM; end
        end
        else if (op == OP_UPDATE && fl_phase >= PH_ARMCHECK && fl_phase <= PH_STAB)
        begin
            el = now - fl_phase_t0;
            if (64'(el) > 64'(c_timeout) * 64'd1000)
            begin
                fl_active = 0;
                fl_phase = PH_ABORTED;
                if (!guided) begin thr = 1; pwm = NEUTRAL_PWM; end
            end
            else if (fl_phase == PH_ARMCHECK)
            begin
                if (armed) begin fl_phase = PH_CLIMB; fl_phase_t0 = now; end
            end
            else if (fl_phase == PH_CLIMB)
            begin
                e = fl_target - longint'(cur);
                if (e > 2097151) e = 2097151;
                if (e < -2097152) e = -2097152;
                ae = e < 0 ? -e : e;
                if (ae < longint'(c_db))
                begin
                    fl_phase = PH_STAB;
                    fl_phase_t0 = now;
                    if (!guided) begin thr = 1; pwm = NEUTRAL_PWM; end
                end
                else
                begin
                    if (guided)
                        cmd = 1;
                    else
                    begin
                        thr = 1;
                        pwm = 11'(1500 + throttle_adjust(e, now));
                        n_pid++;
                    end
                    fl_last_upd = now;
                end
            end
            else if (64'(el) > 64'(c_stab) * 64'd1000)
            begin
                fl_phase = PH_COMPLETE;
                fl_active = 0;
            end
        end
        if (thr && c_ch >= NUM_CHANNELS)
            thr = 0;
        b.phase = fl_phase;
        b.thr = thr;
        b.pwm = thr ? pwm : 11'd0;
        b.chan = thr ? c_ch : 5'd0;
        b.cmd = cmd;
        b.alt = cmd ? fl_target[19:0] : 20'd0;
        b.act = fl_active;
        b.rej = rej;
        return b;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [39:0] now, input logic [19:0] tgt,
                             input logic signed [20:0] cur, input logic armed,
                             input logic guided);
        while ($urandom_range(99) < stall_pct)
            @(negedge clk);
        s_tuser = op;
        s_tdata = {5'd0, guided, armed, cur, tgt, now};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_beats.push_back(fly_step(op, now, tgt, cur, armed, guided));
        if (pending_beats[$].thr) n_thr++;
        if (pending_beats[$].cmd) n_cmd++;
        if (pending_beats[$].phase == PH_ABORTED) n_abort++;
        n_items++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        wait_drained();
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_TIMEOUT:  c_timeout = val;
            REG_STAB:     c_stab = val;
            REG_GAIN_P:   c_gp = longint'(signed'(val[23:0]));
            REG_GAIN_I:   c_gi = longint'(signed'(val[23:0]));
            REG_GAIN_D:   c_gd = longint'(signed'(val[23:0]));
            REG_DEADBAND: c_db = val[15:0];
            REG_CHANNEL:  c_ch = val[4:0];
            default: ;
        endcase
    endtask

    task automatic upd(input int dt_us, input logic signed [20:0] cur, input logic armed,
                       input logic guided);
        clock_us = clock_us + 40'(dt_us);
        send_item(OP_UPDATE, clock_us, 20'd0, cur, armed, guided);
    endtask

    task automatic test_directed();
        clock_us = 40'd1000;
        send_item(OP_UPDATE, clock_us, 20'd5, 21'sd0, 1, 0);
        send_item(OP_START, clock_us, 20'd1000000, 21'sd0, 0, 0);
        send_item(OP_START, clock_us, 20'd7, 21'sd0, 1, 1);
        upd(10000, 21'sd0, 0, 0);
        upd(10000, 21'sd0, 1, 0);
        upd(20000, -21'sd1000000, 1, 0);
        upd(0, -21'sd1000000, 1, 0);
        upd(1, 21'sd999999, 1, 0);
        upd(50000, 21'sd200000, 1, 1);
        send_item(OP_NOP, clock_us, 20'hFFFFF, 21'sd0, 1, 1);
        upd(50000, 21'sd999700, 1, 1);
        upd(1000000, 21'sd999700, 1, 0);
        upd(1500000, 21'sd999700, 1, 0);
        upd(10000, 21'sd999700, 1, 0);
        send_item(OP_ABORT, clock_us, 20'd0, 21'sd0, 0, 1);
        send_item(OP_ABORT, clock_us, 20'd0, 21'sd0, 0, 0);
        clock_us = 40'hFF_FFFF_F000;
        send_item(OP_START, clock_us, 20'd3000, 21'sd0, 0, 0);
        upd(31000000, 21'sd0, 1, 0);
        clock_us = 40'h00_0000_0100;
        send_item(OP_START, clock_us, 20'd3000, 21'sd0, 1, 0);
        clock_us = 40'h00_0000_0080;
        send_item(OP_UPDATE, clock_us, 20'd0, 21'sd0, 1, 0);
    endtask

    task automatic random_flights(input int n);
        int      target, alt, steps, kind;
        logic    guided;
        for (int f = 0; f < n; )
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                send_item(2'($urandom), 40'({$urandom, $urandom}), 20'($urandom),
                          21'($urandom), 1'($urandom), 1'($urandom));
                f++;
                continue;
            end
            if (kind < 20)
                clock_us = 40'({$urandom, $urandom});
            target = $urandom_range(1000000);
            if (kind % 7 == 0) target = 1000000;
            send_item(OP_START, clock_us, 20'(target), 21'($urandom), 1'($urandom), 1'($urandom));
            f++;
            guided = ($urandom_range(3) == 0);
            alt = $urandom_range(2000) - 1000;
            steps = $urandom_range(12, 2);
            for (int s = 0; s < steps && f < n; s++)
            begin
                case ($urandom_range(29))
                    0: send_item(OP_ABORT, clock_us, 20'($urandom), 21'($urandom), 1, guided);
                    1: send_item(OP_START, clock_us, 20'($urandom), 21'($urandom), 1, guided);
                    2: upd($urandom_range(40000000, 20000000), 21'(alt), 1, guided);
                    3: upd(0, 21'(alt), 1, guided);
                    default:
                    begin
                        alt = alt + (target - alt) / int'($urandom_range(4, 1))
                              + int'($urandom_range(800)) - 400;
                        if (alt > 1000000) alt = 1000000;
                        if (alt < -1000000) alt = -1000000;
                        upd($urandom_range(3000000), 21'(alt), ($urandom_range(4) != 0),
                            guided ^ ($urandom_range(9) == 0));
                    end
                endcase
                f++;
            end
        end
    endtask

    task automatic test_gain_settings();
        write_reg(REG_GAIN_P, 32'h007F_FFFF);
        write_reg(REG_GAIN_I, 32'hFF80_0000);
        write_reg(REG_GAIN_D, 32'h0000_0001);
        write_reg(REG_DEADBAND, 32'd65535);
        write_reg(REG_CHANNEL, 32'd17);
        random_flights(120);
        write_reg(REG_GAIN_P, 32'hAB80_0000);
        write_reg(REG_GAIN_I, 32'h547F_FFFF);
        write_reg(REG_GAIN_D, 32'hFF80_0000);
        write_reg(REG_DEADBAND, 32'd0);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_STAB, 32'd0);
        random_flights(120);
        write_reg(REG_GAIN_D, 32'h007F_FFFF);
        write_reg(REG_CHANNEL, 32'd18);
        write_reg(REG_TIMEOUT, 32'd0);
        random_flights(60);
        write_reg(REG_CHANNEL, 32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT, 32'd2000);
        write_reg(REG_STAB, 32'hFFFF_FFFF);
        random_flights(60);
    endtask

    task automatic test_random_mix();
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_GAIN_P, $urandom);
            write_reg(REG_GAIN_I, $urandom);
            write_reg(REG_GAIN_D, $urandom);
            write_reg(REG_DEADBAND, $urandom_range(3000));
            write_reg(REG_CHANNEL, $urandom_range(17));
            write_reg(REG_TIMEOUT, $urandom_range(60000, 5000));
            write_reg(REG_STAB, $urandom_range(5000));
            stall_pct = (k == 2) ? 0 : 34;
            random_flights(110);
        end
    endtask

    initial
    begin
        s_tvalid = 0; s_tdata = '0; s_tuser = OP_UPDATE;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        m_tready = 0; errors = 0; n_items = 0; n_thr = 0; n_cmd = 0; n_abort = 0;
        n_pid = 0; idle_cycles = 0; stall_pct = 34; clock_us = '0;
        c_timeout = 30000; c_stab = 2000; c_gp = 32768; c_gi = 0; c_gd = 0;
        c_db = 500; c_ch = 2;
        fl_phase = PH_IDLE; fl_active = 0; fl_target = 0; fl_phase_t0 = '0;
        fl_last_upd = '0; fl_prev_err = 0; fl_integ = 0;
        rst_n = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_gain_settings();
        test_random_mix();
        wait_drained();
        repeat (20) @(negedge clk);
        $display("covered %0d beats: %0d throttle overrides (%0d from PID), %0d takeoff cmds,",
                 n_items, n_thr, n_pid, n_cmd);
        $display("%0d aborted results, across default, extreme and random register settings",
                 n_abort);
        if (errors == 0)
            $display("** takeoff_sequencer_pid_throttle: PASSED **");
        else
            $display("** takeoff_sequencer_pid_throttle: FAILED **");
        $finish;
    end
endmodule
